// ----- rtl/node_cost_table_with_min_defines.svh -----
// ----------------------------------------------------------------------------
// Node cost table assertion macros
// Shared property forms for the checker of the node cost table.
// ----------------------------------------------------------------------------
`ifndef NODE_COST_TABLE_WITH_MIN_DEFINES_SVH
`define NODE_COST_TABLE_WITH_MIN_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NCT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nct_checker: same-cycle property violated");

// The consequent must hold in the cycle after the antecedent.
`define NCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nct_checker: next-cycle property violated");

`endif

// ----- rtl/nct_pkg.sv -----
// ----------------------------------------------------------------------------
// Node cost table package
// Types and constants shared by the node cost table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package nct_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int COORD_BITS  = 10;
    localparam int NODE_BITS   = 2 * COORD_BITS;
    localparam int COST_BITS   = 32;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [NODE_BITS-1:0]  t_node;
    typedef logic [COST_BITS-1:0]  t_cost;

    localparam t_cost COST_INF = '1;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_LOOKUP   = 2'd2,
        CMD_FIND_MIN = 2'd3
    } t_cmd;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    typedef struct packed {
        t_cmd   command;
        t_coord node_x;
        t_coord node_y;
        t_coord other_x;
        t_coord other_y;
        t_cost  cost_in;
    } t_in_item;

    typedef struct packed {
        logic   hit;
        t_cost  cost_out;
        t_coord pred_x;
        t_coord pred_y;
        logic   edge_match;
        t_coord min_x;
        t_coord min_y;
        logic   table_empty;
        logic   insert_dropped;
    } t_out_item;

    // Node and predecessor hold y in the upper half and x in the lower half.
    typedef struct packed {
        t_node node;
        t_node pred;
        t_cost cost;
    } t_slot;

    typedef struct packed {
        logic  en;
        t_slot data;
    } t_ram_wr;

endpackage

`default_nettype wire

// ----- rtl/nct_slot_ram.sv -----
// ----------------------------------------------------------------------------
// Node cost table slot memory
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nct_slot_ram #(
    parameter int ENTRIES = nct_pkg::ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [$clog2(ENTRIES)-1:0] i_rd_addr,
    output nct_pkg::t_slot             o_rd_data,
    input  logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  nct_pkg::t_ram_wr           i_wr
);
    import nct_pkg::*;

    t_slot r_mem [ENTRIES];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/node_cost_table_with_min.sv -----
// ----------------------------------------------------------------------------
// Node cost table with minimum search
// Each item takes one pass over the n stored entries (n is at most ENTRIES)
// through the single memory read port; on an empty table there is no pass.
// A new item is taken only in the idle state, once the previous result is
// registered, and that result waits while the output is stalled.
// Reset empties the table at once; the memory itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module node_cost_table_with_min #(
    parameter int ENTRIES = nct_pkg::ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  nct_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output nct_pkg::t_out_item o_out_item
);
    import nct_pkg::*;

    localparam int IDX_BITS = $clog2(ENTRIES);
    localparam int CNT_BITS = $clog2(ENTRIES + 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(ENTRIES);

    t_state               r_state, n_state;
    t_in_item             r_item;
    logic [CNT_BITS-1:0]  r_count, n_count;
    logic [CNT_BITS-1:0]  r_addr, n_addr;
    logic                 r_rd_valid, n_rd_valid;
    logic [IDX_BITS-1:0]  r_rd_idx, n_rd_idx;
    logic                 r_found, n_found;
    logic [IDX_BITS-1:0]  r_slot, n_slot;
    t_slot                r_match, n_match;
    logic                 r_have_best, n_have_best;
    t_cost                r_best_cost, n_best_cost;
    t_node                r_best_node, n_best_node;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;

    logic                 in_accept;
    logic                 scan_done;
    logic                 out_free;
    logic                 do_finish;
    logic                 rd_en;
    t_slot                rd_data;
    t_ram_wr              wr;
    logic [IDX_BITS-1:0]  wr_addr;
    t_node                key;
    t_node                other;

    assign key       = {r_item.node_y, r_item.node_x};
    assign other     = {r_item.other_y, r_item.other_x};
    assign in_accept = i_in_valid && o_in_ready;
    assign scan_done = (r_addr == r_count) && !r_rd_valid;
    assign out_free  = !r_out_valid || i_out_ready;

    nct_slot_ram #(
        .ENTRIES (ENTRIES)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr[IDX_BITS-1:0]),
        .o_rd_data (rd_data),
        .i_wr_addr (wr_addr),
        .i_wr      (wr)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        rd_en      = 1'b0;
        do_finish  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_SCAN: begin
                rd_en     = (r_addr != r_count);
                do_finish = scan_done && out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_addr      = r_addr;
        n_rd_valid  = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_found     = r_found;
        n_slot      = r_slot;
        n_match     = r_match;
        n_have_best = r_have_best;
        n_best_cost = r_best_cost;
        n_best_node = r_best_node;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        wr          = '0;
        wr_addr     = '0;

        if (in_accept) begin
            n_addr      = '0;
            n_found     = 1'b0;
            n_have_best = 1'b0;
        end

        if (rd_en) begin
            n_addr     = r_addr + 1'b1;
            n_rd_valid = 1'b1;
            n_rd_idx   = r_addr[IDX_BITS-1:0];
        end

        if (r_rd_valid) begin
            // Entries behind a removed node move down by one slot.
            if (r_found) begin
                if (r_item.command == CMD_REMOVE) begin
                    wr.en   = 1'b1;
                    wr.data = rd_data;
                    wr_addr = r_rd_idx - 1'b1;
                end
            end else if (rd_data.node == key) begin
                n_found = 1'b1;
                n_slot  = r_rd_idx;
                n_match = rd_data;
            end
            // Later entries win ties, so the highest slot with the lowest cost is kept.
            if (!r_have_best || (rd_data.cost <= r_best_cost)) begin
                n_have_best = 1'b1;
                n_best_cost = rd_data.cost;
                n_best_node = rd_data.node;
            end
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (do_finish) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            unique case (r_item.command)
                CMD_INSERT: begin
                    if (r_found) begin
                        wr.en     = 1'b1;
                        wr.data   = '{node: key, pred: other, cost: r_item.cost_in};
                        wr_addr   = r_slot;
                        n_out.hit = 1'b1;
                    end else if (r_count != CNT_FULL) begin
                        wr.en   = 1'b1;
                        wr.data = '{node: key, pred: other, cost: r_item.cost_in};
                        wr_addr = r_count[IDX_BITS-1:0];
                        n_count = r_count + 1'b1;
                    end else begin
                        n_out.insert_dropped = 1'b1;
                    end
                end
                CMD_REMOVE: begin
                    if (r_found) begin
                        n_count   = r_count - 1'b1;
                        n_out.hit = 1'b1;
                    end
                end
                CMD_LOOKUP: begin
                    if (r_found) begin
                        n_out.hit        = 1'b1;
                        n_out.cost_out   = r_match.cost;
                        n_out.pred_x     = r_match.pred[COORD_BITS-1:0];
                        n_out.pred_y     = r_match.pred[NODE_BITS-1:COORD_BITS];
                        n_out.edge_match = (r_match.pred == other);
                    end else begin
                        n_out.cost_out = COST_INF;
                    end
                end
                CMD_FIND_MIN: begin
                    if (r_have_best) begin
                        n_out.hit   = 1'b1;
                        n_out.min_x = r_best_node[COORD_BITS-1:0];
                        n_out.min_y = r_best_node[NODE_BITS-1:COORD_BITS];
                    end
                end
                default: begin
                    n_out = '0;
                end
            endcase
            n_out.table_empty = (n_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in_item;
        end
        r_addr      <= n_addr;
        r_rd_idx    <= n_rd_idx;
        r_found     <= n_found;
        r_slot      <= n_slot;
        r_match     <= n_match;
        r_have_best <= n_have_best;
        r_best_cost <= n_best_cost;
        r_best_node <= n_best_node;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// ----- rtl/nct_checker.sv -----
// ----------------------------------------------------------------------------
// Node cost table checker
// Port-level properties of the node cost table, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "node_cost_table_with_min_defines.svh"

module nct_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire nct_pkg::t_out_item i_out_item
);
    import nct_pkg::*;

    `NCT_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `NCT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `NCT_ASSERT_SAME(a_match_needs_hit, i_clk, i_rst_n, i_out_valid && i_out_item.edge_match, i_out_item.hit)
    `NCT_ASSERT_SAME(a_drop_when_full, i_clk, i_rst_n, i_out_valid && i_out_item.insert_dropped, !i_out_item.hit && !i_out_item.table_empty)

endmodule

bind node_cost_table_with_min nct_checker u_nct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);

`default_nettype wire
